// File: rtl/fcsg_pkg.sv
package fcsg_pkg;

    localparam int COORD_W     = 12;
    localparam int RAD_W       = 4;
    localparam int OFF_W       = 5;
    localparam int DEC_W       = 9;
    localparam int SPAN_W      = 13;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [RAD_W-1:0] MAX_RADIUS = 4'd15;

    // Walk phases: one span per phase, idle loads the next circle
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_UPPER,     // row cy-tx, wide columns
        PH_LOWER,     // row cy+tx, wide columns
        PH_CAP_TOP,   // row cy-ty, narrow columns
        PH_CAP_BOT,   // row cy+ty, narrow columns
        PH_TAIL_TOP,  // diagonal row cy-tx
        PH_TAIL_BOT   // diagonal row cy+tx
    } t_phase;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          radius;
        logic signed [DEC_W-1:0]   d0;
    } t_job;

    typedef struct packed {
        logic signed [SPAN_W-1:0] row;
        logic signed [SPAN_W-1:0] left;
        logic signed [SPAN_W-1:0] right;
        logic                     last;
    } t_span;

    typedef struct packed {
        t_phase           phase;
        logic [OFF_W-1:0] tx;
        logic [OFF_W-1:0] ty;
    } t_back_stat;

endpackage

// File: rtl/filled_circle_span_generator_unit.sv
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------------
// s        in   one circle: centre and radius
// m        out  one horizontal span of the filled disc, tlast on its final span
//
// A circle is first loaded, then the span walker emits one span a cycle into the
// output register while m is not stalled; radius zero gives two spans and radius
// 15 gives 31.
// Reset is synchronous and active low; it empties the queue and idles the walker.
// The front takes a beat whenever the two-entry job queue has room, so it keeps
// accepting while the walker works or while a span waits on a stalled m side.
// A stall on m holds the pending span; the walker freezes but can still load a circle.
module filled_circle_span_generator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // fields from bit 0: center_x[11:0], center_y[23:12], radius[27:24], zero pad
    input  logic [fcsg_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // fields from bit 0: span_row[12:0], span_left[25:13], span_right[38:26], zero pad
    output logic [fcsg_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // last_span
    output logic                            o_m_tlast
);
    import fcsg_pkg::*;

    logic       q_push;
    logic       q_ready;
    t_job       push_job;
    logic       q_valid;
    logic       q_pop;
    t_job       pop_job;
    t_span      out_span;
    t_back_stat stat;

    // classify the incoming beat and hand it to the queue
    fcsg_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_job    (push_job)
    );

    // decouple acceptance from the walk
    fcsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    // walk the decision recurrence, one span per cycle while the output is not stalled
    fcsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (pop_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_span  (out_span),
        .o_stat      (stat)
    );

    assign o_m_tdata = {1'b0, out_span.right, out_span.left, out_span.row};
    assign o_m_tlast = out_span.last;

    // inside the walk proper tx stays below ty
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.phase == PH_UPPER || stat.phase == PH_LOWER ||
         stat.phase == PH_CAP_TOP || stat.phase == PH_CAP_BOT) |-> (stat.tx < stat.ty))
        else $error("walk phase with tx not below ty");

    // the diagonal rows come only with tx equal to ty
    a_tail_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.phase == PH_TAIL_TOP || stat.phase == PH_TAIL_BOT) |-> (stat.tx == stat.ty))
        else $error("tail phase off the diagonal");

    // a pending final span means the walker has finished, or has only loaded the next circle
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
        (stat.phase == PH_IDLE ||
         ((stat.phase == PH_UPPER || stat.phase == PH_TAIL_TOP) && stat.tx == '0)))
        else $error("walker moved on past a pending final span");

    // a span beat leaves the output register empty unless the walker refilled it
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && $past(stat.phase) == PH_IDLE && stat.phase == PH_IDLE)
        |=> !o_m_tvalid)
        else $error("span beat repeated while walker idle");

endmodule

// File: rtl/fcsg_front.sv
module fcsg_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [fcsg_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_q_ready,
    output logic                           o_q_push,
    output fcsg_pkg::t_job                 o_q_job
);
    import fcsg_pkg::*;

    logic [RAD_W-1:0] rad_in;
    logic [RAD_W-1:0] rad_sat;

    assign rad_in  = i_s_tdata[2*COORD_W +: RAD_W];
    // clamp oversize radius
    assign rad_sat = (rad_in > MAX_RADIUS) ? MAX_RADIUS : rad_in;

    assign o_s_tready      = i_q_ready;
    assign o_q_push        = i_s_tvalid && i_q_ready;
    assign o_q_job.cx      = $signed(i_s_tdata[0 +: COORD_W]);
    assign o_q_job.cy      = $signed(i_s_tdata[COORD_W +: COORD_W]);
    assign o_q_job.radius  = rad_sat;
    // initial decision value 3 - 2r
    assign o_q_job.d0      = $signed(DEC_W'(3)) - $signed({4'b0000, rad_sat, 1'b0});

endmodule

// File: rtl/fcsg_queue.sv
module fcsg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcsg_pkg::t_job i_job,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output fcsg_pkg::t_job o_job
);
    import fcsg_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/fcsg_back.sv
module fcsg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  fcsg_pkg::t_job          i_q_job,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output fcsg_pkg::t_span         o_out_span,
    output fcsg_pkg::t_back_stat    o_stat
);
    import fcsg_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [OFF_W-1:0]        r_tx;
    logic [OFF_W-1:0]        r_ty;
    logic signed [DEC_W-1:0] r_d;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic                    r_out_valid;
    t_span                   r_out;

    logic                    advance;
    logic                    d_neg;
    logic [OFF_W-1:0]        tx1;
    logic [OFF_W-1:0]        ty1;
    t_phase                  step_next;
    logic signed [DEC_W-1:0] d_next;
    logic signed [DEC_W-1:0] diff;
    logic                    emit;
    logic                    step_end;
    t_span                   span;
    logic signed [SPAN_W-1:0] cx13, cy13, tx13, ty13;

    assign advance = !r_out_valid || i_out_ready;
    assign d_neg   = r_d[DEC_W-1];
    assign tx1     = r_tx + OFF_W'(1);
    assign ty1     = d_neg ? r_ty : (r_ty - OFF_W'(1));
    assign step_next = (tx1 < ty1) ? PH_UPPER : ((tx1 == ty1) ? PH_TAIL_TOP : PH_IDLE);
    assign diff    = $signed({4'b0000, r_tx}) - $signed({4'b0000, r_ty});
    assign d_next  = d_neg ? (r_d + $signed({2'b00, r_tx, 2'b00}) + $signed(DEC_W'(6)))
                           : (r_d + $signed({diff[DEC_W-3:0], 2'b00}) + $signed(DEC_W'(10)));

    assign cx13 = {r_cx[COORD_W-1], r_cx};
    assign cy13 = {r_cy[COORD_W-1], r_cy};
    assign tx13 = $signed({{(SPAN_W-OFF_W){1'b0}}, r_tx});
    assign ty13 = $signed({{(SPAN_W-OFF_W){1'b0}}, r_ty});

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_q_valid) begin
                    n_phase = (i_q_job.radius != '0) ? PH_UPPER : PH_TAIL_TOP;
                end
            end
            PH_UPPER: begin
                if (advance) begin
                    if (r_tx != '0) begin
                        n_phase = PH_LOWER;
                    end else begin
                        n_phase = d_neg ? step_next : PH_CAP_TOP;
                    end
                end
            end
            PH_LOWER: begin
                if (advance) begin
                    n_phase = d_neg ? step_next : PH_CAP_TOP;
                end
            end
            PH_CAP_TOP:  if (advance) n_phase = PH_CAP_BOT;
            PH_CAP_BOT:  if (advance) n_phase = step_next;
            PH_TAIL_TOP: if (advance) n_phase = PH_TAIL_BOT;
            PH_TAIL_BOT: if (advance) n_phase = PH_IDLE;
            default:     n_phase = PH_IDLE;
        endcase
    end

    // span selection and step bookkeeping
    always_comb begin
        emit       = 1'b1;
        step_end   = 1'b0;
        span.row   = cy13 - tx13;
        span.left  = cx13 - ty13;
        span.right = cx13 + ty13;
        span.last  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                emit = 1'b0;
            end
            PH_UPPER: begin
                step_end = (r_tx == '0) && d_neg;
            end
            PH_LOWER: begin
                span.row = cy13 + tx13;
                step_end = d_neg;
            end
            PH_CAP_TOP: begin
                span.row   = cy13 - ty13;
                span.left  = cx13 - tx13;
                span.right = cx13 + tx13;
            end
            PH_CAP_BOT: begin
                span.row   = cy13 + ty13;
                span.left  = cx13 - tx13;
                span.right = cx13 + tx13;
                step_end   = 1'b1;
            end
            PH_TAIL_TOP: begin
            end
            PH_TAIL_BOT: begin
                span.row  = cy13 + tx13;
                span.last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (step_end && (step_next == PH_IDLE)) begin
            span.last = 1'b1;
        end
    end

    assign o_q_pop     = (r_phase == PH_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_span  = r_out;
    assign o_stat.phase = r_phase;
    assign o_stat.tx    = r_tx;
    assign o_stat.ty    = r_ty;

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= span;
        end
        if (o_q_pop) begin
            r_cx <= i_q_job.cx;
            r_cy <= i_q_job.cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_tx        <= '0;
            r_ty        <= '0;
            r_d         <= '0;
        end else begin
            r_phase <= n_phase;
            if (advance) begin
                r_out_valid <= emit;
            end
            if (o_q_pop) begin
                r_tx <= '0;
                r_ty <= {1'b0, i_q_job.radius};
                r_d  <= i_q_job.d0;
            end else if (advance && step_end) begin
                r_tx <= tx1;
                r_ty <= ty1;
                r_d  <= d_next;
            end
        end
    end

endmodule
